FILE: sv/stunmap_pkg.sv
// Shared types, protocol constants and helpers for the STUN mapped-address parser.
package stunmap_pkg;

  // Verdict codes, also used for the first header error seen in a packet.
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_SHORT    = 3'd1,
    STAT_TYPE     = 3'd2,
    STAT_LENGTH   = 3'd3,
    STAT_COOKIE   = 3'd4,
    STAT_TXID     = 3'd5,
    STAT_OVERRUN  = 3'd6,
    STAT_NONE     = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FAMILY    = 2'd0,
    REG_SEED_HEAD = 2'd1,
    REG_SEED_TAIL = 2'd2
  } cfg_reg_e;

  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned TXID_BYTES = 12;
  localparam int unsigned ADDR_BYTES = 16;
  localparam int unsigned HDR_BYTES  = 20;
  // Wide enough for an attribute end offset: start + 4 + padded 16-bit length.
  localparam int unsigned SUM_W      = 18;

  localparam logic [31:0] COOKIE       = 32'h2112_a442;
  localparam logic [7:0]  TYPE_HI      = 8'h01;
  localparam logic [7:0]  TYPE_LO      = 8'h01;
  localparam logic [15:0] ATTR_MAPPED  = 16'h0001;
  localparam logic [15:0] ATTR_XMAPPED = 16'h0020;
  localparam logic [1:0]  FAM_V6       = 2'h2;

  // Byte k of the magic cookie, most significant byte first.
  function automatic logic [7:0] cookie_byte(input logic [1:0] k);
    logic [7:0] res;
    unique case (k)
      2'd0:    res = COOKIE[31:24];
      2'd1:    res = COOKIE[23:16];
      2'd2:    res = COOKIE[15:8];
      default: res = COOKIE[7:0];
    endcase
    return res;
  endfunction

endpackage

FILE: sv/stun_mapped_address_parser_core.sv
// Top level of the STUN binding-response mapped-address parser.
// Path: a byte is taken into the input register and parsed there; when a packet's last
//   byte is parsed, its verdict is loaded into the verdict register for the master side.
// Throughput: one byte per cycle, set by the single-pass parse stage; the slave side
//   stalls only while a verdict waits on the master side and the next last byte is due.
// Reset: rst_ni is asynchronous and active low; it empties both registers, returns the
//   packet state to its idle values and sets the family to IPv4 and both seeds to zero.
module stun_mapped_address_parser_core #(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [stunmap_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [stunmap_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Packet bytes in.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [7:0]                             s_axis_tdata,   // data_byte
  input  logic                                   s_axis_tlast,   // last_byte
  // Verdicts out.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // status[2:0], addr_head[66:3], addr_tail[130:67], mapped_port[146:131], zero fill
  output logic [151:0]                           m_axis_tdata,
  output logic                                   m_axis_tuser    // from_xor
);

  // The byte counter must hold MAX_PACKET itself.
  localparam int unsigned CW    = $clog2(MAX_PACKET + 1);
  localparam int unsigned SUM_W = stunmap_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write only while idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [1:0]  family_q;
  logic [63:0] seed_head_q;
  logic [23:0] seed_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q    <= 2'd1;
      seed_head_q <= '0;
      seed_tail_q <= '0;
    end else if (cfg_we_i) begin
      unique case (stunmap_pkg::cfg_reg_e'(cfg_index_i))
        stunmap_pkg::REG_FAMILY:    family_q    <= cfg_data_i[1:0];
        stunmap_pkg::REG_SEED_HEAD: seed_head_q <= cfg_data_i;
        stunmap_pkg::REG_SEED_TAIL: seed_tail_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The parse stage advances unless it holds a last byte and the
  // verdict register is still full and not being taken.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       advance;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet state.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]              byte_count_q, byte_count_d;
  logic [15:0]                msg_len_q, msg_len_d;
  stunmap_pkg::status_e       hdr_err_q, hdr_err_d;
  logic [7:0]                 txid_q [stunmap_pkg::TXID_BYTES];
  logic [7:0]                 txid_d [stunmap_pkg::TXID_BYTES];
  logic [CW-1:0]              start_q, start_d;
  logic [15:0]                attr_type_q, attr_type_d;
  logic [15:0]                attr_len_q, attr_len_d;
  logic                       cand_q, cand_d;
  logic [7:0]                 addr_q [stunmap_pkg::ADDR_BYTES];
  logic [7:0]                 addr_d [stunmap_pkg::ADDR_BYTES];
  logic [15:0]                port_q, port_d;
  logic                       found_q, found_d;
  logic                       overrun_q, overrun_d;
  logic                       walk_done_q, walk_done_d;

  // Verdict register.
  stunmap_pkg::status_e       out_status_q, out_status_d;
  logic [63:0]                out_head_q, out_head_d;
  logic [63:0]                out_tail_q, out_tail_d;
  logic [15:0]                out_port_q, out_port_d;
  logic                       out_xor_q, out_xor_d;
  logic                       out_valid_d;

  // Working signals of the parse stage.
  logic                       take;
  logic                       verdict;
  logic [CW-1:0]              p;
  logic [CW-1:0]              start;
  logic [CW-1:0]              rel;
  logic [CW-1:0]              vi;
  logic [3:0]                 k;
  logic [3:0]                 hdr_idx;
  logic [CW-1:0]              alen;
  logic                       xr;
  logic [7:0]                 mask;
  logic [SUM_W-1:0]           attr_end;
  logic [87:0]                seed_vec;
  logic [7:0]                 seed_byte;

  assign take    = advance && (byte_count_q < CW'(MAX_PACKET));
  assign verdict = advance && in_last_q;
  assign p       = byte_count_q;
  // A header byte index runs over the transaction id starting at byte 8.
  assign hdr_idx  = 4'(p - CW'(8));
  assign seed_vec = {seed_head_q, seed_tail_q};
  assign seed_byte = seed_vec[(7'd87 - {hdr_idx, 3'b000}) -: 8];
  // The padded end of the current attribute's value.
  assign attr_end = SUM_W'(start_q) + SUM_W'(4)
                  + ((SUM_W'(attr_len_q) + SUM_W'(3)) & ~SUM_W'(3));
  assign alen = (family_q == stunmap_pkg::FAM_V6) ? CW'(16) : CW'(4);
  assign xr   = (attr_type_q == stunmap_pkg::ATTR_XMAPPED);

  always_comb begin
    byte_count_d = byte_count_q;
    msg_len_d    = msg_len_q;
    hdr_err_d    = hdr_err_q;
    txid_d       = txid_q;
    start_d      = start_q;
    attr_type_d  = attr_type_q;
    attr_len_d   = attr_len_q;
    cand_d       = cand_q;
    addr_d       = addr_q;
    port_d       = port_q;
    found_d      = found_q;
    overrun_d    = overrun_q;
    walk_done_d  = walk_done_q;
    start        = start_q;
    rel          = '0;
    vi           = '0;
    k            = '0;
    mask         = '0;

    if (take) begin
      byte_count_d = byte_count_q + CW'(1);
      if (p < CW'(stunmap_pkg::HDR_BYTES)) begin
        // Fixed header: type, length, cookie, transaction id.
        if (p == CW'(0)) begin
          if (in_byte_q != stunmap_pkg::TYPE_HI && hdr_err_d == stunmap_pkg::STAT_OK)
            hdr_err_d = stunmap_pkg::STAT_TYPE;
        end else if (p == CW'(1)) begin
          if (in_byte_q != stunmap_pkg::TYPE_LO && hdr_err_d == stunmap_pkg::STAT_OK)
            hdr_err_d = stunmap_pkg::STAT_TYPE;
        end else if (p == CW'(2)) begin
          msg_len_d = {in_byte_q, 8'h00};
        end else if (p == CW'(3)) begin
          msg_len_d = {msg_len_q[15:8], in_byte_q};
        end else if (p < CW'(8)) begin
          if (in_byte_q != stunmap_pkg::cookie_byte(p[1:0])
              && hdr_err_d == stunmap_pkg::STAT_OK)
            hdr_err_d = stunmap_pkg::STAT_COOKIE;
        end else begin
          txid_d[hdr_idx] = in_byte_q;
          // The last transaction id byte is not compared with the seed.
          if (p < CW'(8 + stunmap_pkg::TXID_BYTES - 1) && in_byte_q != seed_byte
              && hdr_err_d == stunmap_pkg::STAT_OK)
            hdr_err_d = stunmap_pkg::STAT_TXID;
        end
      end else if (!found_q && !walk_done_q) begin
        // Attribute walk: step to the next attribute at the padded end.
        if (SUM_W'(p) == attr_end) begin
          start   = p;
          start_d = p;
        end
        if (p == start && SUM_W'(start) + SUM_W'(4)
            > SUM_W'(stunmap_pkg::HDR_BYTES) + SUM_W'(msg_len_q)) begin
          // No further attribute fits the declared length.
          walk_done_d = 1'b1;
          overrun_d   = 1'b0;
        end else begin
          rel = p - start;
          if (rel == CW'(0)) begin
            attr_type_d = {in_byte_q, 8'h00};
          end else if (rel == CW'(1)) begin
            attr_type_d = {attr_type_q[15:8], in_byte_q};
          end else if (rel == CW'(2)) begin
            attr_len_d = {in_byte_q, 8'h00};
          end else if (rel == CW'(3)) begin
            attr_len_d = {attr_len_q[15:8], in_byte_q};
            cand_d = (attr_type_q == stunmap_pkg::ATTR_XMAPPED
                      || attr_type_q == stunmap_pkg::ATTR_MAPPED)
                     && attr_len_d >= 16'(4) + 16'(alen);
          end else if (cand_q) begin
            vi = rel - CW'(4);
            if (vi == CW'(1)) begin
              if (in_byte_q != {6'b0, family_q}) cand_d = 1'b0;
            end else if (vi == CW'(2)) begin
              port_d = {in_byte_q, 8'h00};
            end else if (vi == CW'(3)) begin
              port_d = {port_q[15:8], in_byte_q}
                     ^ (xr ? stunmap_pkg::COOKIE[31:16] : 16'h0000);
            end else if (vi >= CW'(4) && vi < CW'(4) + alen) begin
              k = 4'(vi - CW'(4));
              if (xr) begin
                mask = (k < 4'd4) ? stunmap_pkg::cookie_byte(k[1:0])
                                  : txid_q[4'(k - 4'd4)];
              end
              addr_d[k] = in_byte_q ^ mask;
            end
            if (cand_d && SUM_W'(rel) == SUM_W'(3) + SUM_W'(attr_len_q)) found_d = 1'b1;
          end
          overrun_d = !found_d && rel >= CW'(3)
                      && SUM_W'(rel) < SUM_W'(3) + SUM_W'(attr_len_d);
        end
      end
    end

    // Verdict from the state as it stands after this byte.
    priority if (byte_count_d < CW'(stunmap_pkg::HDR_BYTES))
      out_status_d = stunmap_pkg::STAT_SHORT;
    else if (hdr_err_d == stunmap_pkg::STAT_TYPE)
      out_status_d = stunmap_pkg::STAT_TYPE;
    else if (SUM_W'(stunmap_pkg::HDR_BYTES) + SUM_W'(msg_len_d) > SUM_W'(byte_count_d))
      out_status_d = stunmap_pkg::STAT_LENGTH;
    else if (hdr_err_d != stunmap_pkg::STAT_OK)
      out_status_d = hdr_err_d;
    else if (found_d)
      out_status_d = stunmap_pkg::STAT_OK;
    else if (overrun_d)
      out_status_d = stunmap_pkg::STAT_OVERRUN;
    else
      out_status_d = stunmap_pkg::STAT_NONE;

    out_head_d = '0;
    out_tail_d = '0;
    out_port_d = '0;
    out_xor_d  = 1'b0;
    if (out_status_d == stunmap_pkg::STAT_OK) begin
      for (int i = 0; i < 8; i++) begin
        out_head_d[63 - 8 * i -: 8] = addr_d[i];
        out_tail_d[63 - 8 * i -: 8] = addr_d[i + 8];
      end
      out_port_d = port_d;
      out_xor_d  = (attr_type_d == stunmap_pkg::ATTR_XMAPPED);
    end

    // A verdict returns all packet state to idle.
    if (verdict) begin
      byte_count_d = '0;
      msg_len_d    = '0;
      hdr_err_d    = stunmap_pkg::STAT_OK;
      start_d      = CW'(stunmap_pkg::HDR_BYTES);
      attr_type_d  = '0;
      attr_len_d   = '0;
      cand_d       = 1'b0;
      port_d       = '0;
      found_d      = 1'b0;
      overrun_d    = 1'b0;
      walk_done_d  = 1'b0;
      for (int i = 0; i < stunmap_pkg::TXID_BYTES; i++) txid_d[i] = '0;
      for (int i = 0; i < stunmap_pkg::ADDR_BYTES; i++) addr_d[i] = '0;
    end

    if (verdict)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      msg_len_q    <= '0;
      hdr_err_q    <= stunmap_pkg::STAT_OK;
      start_q      <= CW'(stunmap_pkg::HDR_BYTES);
      attr_type_q  <= '0;
      attr_len_q   <= '0;
      cand_q       <= 1'b0;
      port_q       <= '0;
      found_q      <= 1'b0;
      overrun_q    <= 1'b0;
      walk_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < stunmap_pkg::TXID_BYTES; i++) txid_q[i] <= '0;
      for (int i = 0; i < stunmap_pkg::ADDR_BYTES; i++) addr_q[i] <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      msg_len_q    <= msg_len_d;
      hdr_err_q    <= hdr_err_d;
      start_q      <= start_d;
      attr_type_q  <= attr_type_d;
      attr_len_q   <= attr_len_d;
      cand_q       <= cand_d;
      port_q       <= port_d;
      found_q      <= found_d;
      overrun_q    <= overrun_d;
      walk_done_q  <= walk_done_d;
      out_valid_q  <= out_valid_d;
      txid_q       <= txid_d;
      addr_q       <= addr_d;
    end
  end

  // Verdict payload, loaded only when a packet closes.
  always_ff @(posedge clk_i) begin
    if (verdict) begin
      out_status_q <= out_status_d;
      out_head_q   <= out_head_d;
      out_tail_q   <= out_tail_d;
      out_port_q   <= out_port_d;
      out_xor_q    <= out_xor_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_port_q, out_tail_q, out_head_q, out_status_q};
  assign m_axis_tuser  = out_xor_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_found_not_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !overrun_q)
    else $error("found and overrun flags both set");

  a_verdict_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict |=> m_axis_tvalid)
    else $error("closed packet produced no verdict");

  a_verdict_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict |=> (byte_count_q == '0 && !found_q && !walk_done_q
                 && hdr_err_q == stunmap_pkg::STAT_OK))
    else $error("packet state not cleared after verdict");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CW'(MAX_PACKET))
    else $error("byte count beyond packet limit");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != stunmap_pkg::STAT_OK)
      |-> (out_head_q == '0 && out_tail_q == '0 && out_port_q == '0 && !out_xor_q))
    else $error("failed verdict carries address data");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the STUN mapped-address parser: packet stimulus and verdict checks.
module tb_top;

  localparam int unsigned MAX_PACKET      = 512;
  // Margin to wait once every predicted verdict has been seen, before touching the
  // registers or ending the run.
  localparam int unsigned SETTLE_CYCLES   = 6;
  // Longest stretch without any transaction on either side before the run is called hung.
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  // One verdict as the block should present it on the master side.
  typedef struct {
    stunmap_pkg::status_e status;
    logic [63:0]          addr_hi;
    logic [63:0]          addr_lo;
    logic [15:0]          port;
    logic                 from_xor;
  } verdict_t;

  // Which attribute type the packet builder puts on the wire.
  typedef enum int {
    KIND_ANY,
    KIND_MAPPED,
    KIND_XOR,
    KIND_OTHER
  } attr_kind_e;

  // Knobs for one generated packet. Negative values of fam_byte, len_field and
  // flip_at mean "leave it as a well-formed packet would have it".
  typedef struct {
    int         n_attr;
    attr_kind_e kind;
    bit         proper;
    int         fam_byte;
    int         len_field;
    int         flip_at;
    int         cut_at;
    int         extra;
    int         long_body;
    bit         noise;
  } pkt_shape_t;

  // Scoreboard: keeps its own copy of the registers and the packet parse state,
  // predicts the verdict when a last byte is accepted and checks what comes out.
  class verdict_scoreboard;
    logic [1:0]  family;
    logic [63:0] seed_hi;
    logic [23:0] seed_lo;

    int unsigned          byte_cnt;
    int unsigned          msg_len;
    stunmap_pkg::status_e hdr_err;
    logic [7:0]           txid_b [stunmap_pkg::TXID_BYTES];
    int unsigned          next_off;
    logic [15:0]          attr_type;
    int unsigned          attr_len;
    logic                 candidate;
    logic [7:0]           addr_b [stunmap_pkg::ADDR_BYTES];
    logic [15:0]          port;
    logic                 found;
    logic                 overrun;
    logic                 walk_done;

    verdict_t    pending_verdicts[$];
    int          errors;

    function new();
      family  = 2'd1;
      seed_hi = '0;
      seed_lo = '0;
      errors  = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_cnt  = 0;
      msg_len   = 0;
      hdr_err   = stunmap_pkg::STAT_OK;
      foreach (txid_b[i]) txid_b[i] = 8'h00;
      next_off  = stunmap_pkg::HDR_BYTES;
      attr_type = 16'h0000;
      attr_len  = 0;
      candidate = 1'b0;
      foreach (addr_b[i]) addr_b[i] = 8'h00;
      port      = 16'h0000;
      found     = 1'b0;
      overrun   = 1'b0;
      walk_done = 1'b0;
    endfunction

    function void set_reg(stunmap_pkg::cfg_reg_e idx, logic [63:0] val);
      case (idx)
        stunmap_pkg::REG_FAMILY:    family  = val[1:0];
        stunmap_pkg::REG_SEED_HEAD: seed_hi = val;
        stunmap_pkg::REG_SEED_TAIL: seed_lo = val[23:0];
        default: ;
      endcase
    endfunction

    // Only the first header error of a packet is kept.
    function void flag_header(stunmap_pkg::status_e code);
      if (hdr_err == stunmap_pkg::STAT_OK) hdr_err = code;
    endfunction

    function void parse_header_byte(int unsigned p, logic [7:0] b);
      logic [87:0] seed_all;
      seed_all = {seed_hi, seed_lo};
      if (p < 2) begin
        if (b != ((p == 0) ? stunmap_pkg::TYPE_HI : stunmap_pkg::TYPE_LO))
          flag_header(stunmap_pkg::STAT_TYPE);
      end else if (p == 2) begin
        msg_len = {16'd0, b, 8'd0};
      end else if (p == 3) begin
        msg_len = msg_len | {24'd0, b};
      end else if (p < 8) begin
        if (b != stunmap_pkg::COOKIE[31 - 8 * (p - 4) -: 8])
          flag_header(stunmap_pkg::STAT_COOKIE);
      end else begin
        txid_b[p - 8] = b;
        // The last transaction id byte is random per packet and never compared.
        if (p < 8 + stunmap_pkg::TXID_BYTES - 1 && b != seed_all[87 - 8 * (p - 8) -: 8])
          flag_header(stunmap_pkg::STAT_TXID);
      end
    endfunction

    function void walk_attr_byte(int unsigned p, logic [7:0] b);
      int unsigned start, rel, alen, vi, k;
      logic        xr;
      logic [7:0]  m;
      alen = (family == stunmap_pkg::FAM_V6) ? 16 : 4;
      if (found || walk_done) return;
      start = next_off;
      // Step to the next attribute once the padded value of this one is behind us.
      if (p >= start + 4 && p == start + 4 + ((attr_len + 3) & 32'hffff_fffc)) begin
        start    = p;
        next_off = p;
      end
      if (p == start && start + 4 > stunmap_pkg::HDR_BYTES + msg_len) begin
        walk_done = 1'b1;
        overrun   = 1'b0;
        return;
      end
      rel = p - start;
      if (rel == 0) begin
        attr_type = {b, 8'h00};
      end else if (rel == 1) begin
        attr_type[7:0] = b;
      end else if (rel == 2) begin
        attr_len = {16'd0, b, 8'd0};
      end else if (rel == 3) begin
        attr_len  = attr_len | {24'd0, b};
        candidate = (attr_type == stunmap_pkg::ATTR_XMAPPED ||
                     attr_type == stunmap_pkg::ATTR_MAPPED) &&
                    attr_len >= 4 + alen;
      end else if (candidate) begin
        vi = rel - 4;
        xr = (attr_type == stunmap_pkg::ATTR_XMAPPED);
        if (vi == 1) begin
          if (b != {6'd0, family}) candidate = 1'b0;
        end else if (vi == 2) begin
          port = {b, 8'h00};
        end else if (vi == 3) begin
          port = {port[15:8], b} ^ (xr ? stunmap_pkg::COOKIE[31:16] : 16'h0000);
        end else if (vi >= 4 && vi < 4 + alen) begin
          k = vi - 4;
          m = 8'h00;
          // XOR-MAPPED masks the first four address bytes with the cookie and
          // the rest with the packet's own transaction id.
          if (xr) m = (k < 4) ? stunmap_pkg::COOKIE[31 - 8 * k -: 8]
                              : txid_b[(k - 4) % stunmap_pkg::TXID_BYTES];
          addr_b[k[3:0]] = b ^ m;
        end
        if (candidate && p == start + 3 + attr_len) found = 1'b1;
      end
      overrun = !found && rel >= 3 && p + 1 < start + 4 + attr_len;
    endfunction

    // Called for every accepted input transaction.
    function void take_byte(logic [7:0] b, logic last);
      verdict_t v;
      int       k;
      // Bytes past the receive buffer are dropped, but a last mark still closes the packet.
      if (byte_cnt < MAX_PACKET) begin
        if (byte_cnt < stunmap_pkg::HDR_BYTES) parse_header_byte(byte_cnt, b);
        else walk_attr_byte(byte_cnt, b);
        byte_cnt++;
      end
      if (!last) return;
      v.addr_hi  = '0;
      v.addr_lo  = '0;
      v.port     = '0;
      v.from_xor = 1'b0;
      if (byte_cnt < stunmap_pkg::HDR_BYTES) v.status = stunmap_pkg::STAT_SHORT;
      else if (hdr_err == stunmap_pkg::STAT_TYPE) v.status = stunmap_pkg::STAT_TYPE;
      else if (stunmap_pkg::HDR_BYTES + msg_len > byte_cnt) v.status = stunmap_pkg::STAT_LENGTH;
      else if (hdr_err != stunmap_pkg::STAT_OK) v.status = hdr_err;
      else if (found) v.status = stunmap_pkg::STAT_OK;
      else if (overrun) v.status = stunmap_pkg::STAT_OVERRUN;
      else v.status = stunmap_pkg::STAT_NONE;
      if (v.status == stunmap_pkg::STAT_OK) begin
        for (k = 0; k < 8; k++) begin
          v.addr_hi = {v.addr_hi[55:0], addr_b[k]};
          v.addr_lo = {v.addr_lo[55:0], addr_b[k + 8]};
        end
        v.port     = port;
        v.from_xor = (attr_type == stunmap_pkg::ATTR_XMAPPED);
      end
      pending_verdicts.push_back(v);
      clear_packet();
    endfunction

    // Called for every accepted output transaction.
    function void check_verdict(logic [151:0] d, logic xr);
      verdict_t             v;
      stunmap_pkg::status_e got;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none pending: status %0d", d[2:0]);
        errors++;
        return;
      end
      v   = pending_verdicts.pop_front();
      got = stunmap_pkg::status_e'(d[2:0]);
      if (d[2:0] != v.status) begin
        $error("status: expected %s, got %s", v.status.name(), got.name());
        errors++;
      end
      if (d[66:3] != v.addr_hi) begin
        $error("addr_head: expected %h, got %h", v.addr_hi, d[66:3]);
        errors++;
      end
      if (d[130:67] != v.addr_lo) begin
        $error("addr_tail: expected %h, got %h", v.addr_lo, d[130:67]);
        errors++;
      end
      if (d[146:131] != v.port) begin
        $error("mapped_port: expected %h, got %h", v.port, d[146:131]);
        errors++;
      end
      if (xr != v.from_xor) begin
        $error("from_xor: expected %b, got %b", v.from_xor, xr);
        errors++;
      end
      if (d[151:147] != 5'd0) begin
        $error("tdata fill: expected 0, got %h", d[151:147]);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [stunmap_pkg::REG_IDX_W-1:0]  cfg_index;
  logic [stunmap_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [7:0]                         s_axis_tdata;
  logic                               s_axis_tlast;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [151:0]                       m_axis_tdata;
  logic                               m_axis_tuser;

  verdict_scoreboard board = new();
  int                sent_bytes   = 0;
  int                quiet_cycles = 0;
  int                sink_hold    = 0;

  stun_mapped_address_parser_core #(
    .MAX_PACKET(MAX_PACKET)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Idle lengths for both sides: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pkt_shape_t base_shape();
    pkt_shape_t sh;
    sh.n_attr    = 1;
    sh.kind      = KIND_MAPPED;
    sh.proper    = 1'b1;
    sh.fam_byte  = -1;
    sh.len_field = -1;
    sh.flip_at   = -1;
    sh.cut_at    = 0;
    sh.extra     = 0;
    sh.long_body = 0;
    sh.noise     = 1'b0;
    return sh;
  endfunction

  // Most random packets are well formed with random content, so that the attribute
  // walk is reached; a minority get broken headers, bad lengths, cuts or pure noise.
  function automatic pkt_shape_t random_shape();
    pkt_shape_t sh;
    sh        = base_shape();
    sh.n_attr = $urandom_range(0, 3);
    sh.kind   = KIND_ANY;
    sh.proper = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 4) == 0)
      sh.fam_byte = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) sh.flip_at = $urandom_range(0, 19);
    if ($urandom_range(0, 9) == 0)
      sh.len_field = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                                                   $urandom_range(0, 48);
    if ($urandom_range(0, 9) == 0) sh.cut_at = $urandom_range(1, 48);
    if ($urandom_range(0, 7) == 0) sh.extra = $urandom_range(1, 8);
    if ($urandom_range(0, 24) == 0) sh.noise = 1'b1;
    return sh;
  endfunction

  // Builds one packet from its shape and the current register copy, then streams it
  // byte by byte with random gaps; each accepted byte goes to the scoreboard.
  task automatic send_shape(input pkt_shape_t sh);
    logic [7:0]  pkt_q[$];
    logic [7:0]  body[$];
    logic [87:0] seed_all;
    logic [15:0] atype;
    logic [15:0] mlen;
    logic [7:0]  fam;
    attr_kind_e  kind;
    int unsigned vlen;
    int          n, t, gap;
    bit          quiet, is_last;
    seed_all = {board.seed_hi, board.seed_lo};
    if (sh.noise) begin
      n = $urandom_range(1, 40);
      repeat (n) pkt_q.push_back(8'($urandom));
    end else begin
      // Filler attributes of an unknown type push the interesting part toward the
      // end of the receive buffer.
      while (body.size() < sh.long_body) begin
        body.push_back(8'h80);
        body.push_back(8'h28);
        body.push_back(8'h00);
        body.push_back(8'd28);
        repeat (28) body.push_back(8'($urandom));
      end
      for (n = 0; n < sh.n_attr; n++) begin
        kind  = (sh.kind == KIND_ANY) ? attr_kind_e'($urandom_range(1, 3)) : sh.kind;
        atype = (kind == KIND_MAPPED) ? stunmap_pkg::ATTR_MAPPED :
                (kind == KIND_XOR)    ? stunmap_pkg::ATTR_XMAPPED : 16'($urandom);
        vlen  = sh.proper ? ((board.family == stunmap_pkg::FAM_V6) ? 20 : 8) :
                            $urandom_range(0, 24);
        fam   = (sh.fam_byte < 0) ? {6'd0, board.family} : 8'(sh.fam_byte);
        body.push_back(atype[15:8]);
        body.push_back(atype[7:0]);
        body.push_back(8'(vlen >> 8));
        body.push_back(8'(vlen));
        for (t = 0; t < vlen; t++) body.push_back((t == 1) ? fam : 8'($urandom));
        while (body.size() % 4 != 0) body.push_back(8'($urandom));
      end
      mlen = (sh.len_field < 0) ? 16'(body.size()) : 16'(sh.len_field);
      pkt_q.push_back(stunmap_pkg::TYPE_HI);
      pkt_q.push_back(stunmap_pkg::TYPE_LO);
      pkt_q.push_back(mlen[15:8]);
      pkt_q.push_back(mlen[7:0]);
      for (t = 0; t < 4; t++) pkt_q.push_back(stunmap_pkg::COOKIE[31 - 8 * t -: 8]);
      for (t = 0; t < 11; t++) pkt_q.push_back(seed_all[87 - 8 * t -: 8]);
      pkt_q.push_back(8'($urandom));
      foreach (body[i]) pkt_q.push_back(body[i]);
      repeat (sh.extra) pkt_q.push_back(8'($urandom));
      if (sh.flip_at >= 0 && sh.flip_at < pkt_q.size())
        pkt_q[sh.flip_at] = pkt_q[sh.flip_at] ^ 8'(1 << $urandom_range(0, 7));
      if (sh.cut_at > 0)
        while (pkt_q.size() > sh.cut_at) void'(pkt_q.pop_back());
    end

    // Some packets have their bytes sent back to back with no idle cycles at all.
    quiet = ($urandom_range(0, 3) == 0);
    foreach (pkt_q[i]) begin
      gap     = quiet ? 0 : pick_gap();
      is_last = (i == pkt_q.size() - 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pkt_q[i];
      s_axis_tlast  <= is_last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      board.take_byte(pkt_q[i], is_last);
      sent_bytes++;
    end
  endtask

  // Stop sending and wait until every predicted verdict has been seen, plus a margin.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles; only called while the block is idle.
  task automatic set_config(input logic [63:0] fam_word, input logic [63:0] head_word,
                            input logic [63:0] tail_word);
    logic [63:0]            words [3];
    stunmap_pkg::cfg_reg_e  idx;
    int                     i;
    words = '{fam_word, head_word, tail_word};
    for (i = 0; i < 3; i++) begin
      idx = stunmap_pkg::cfg_reg_e'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= words[i];
      @(posedge clk);
      board.set_reg(idx, words[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] seed_word();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    return {32'($urandom), 32'($urandom)};
  endfunction

  // Output side: checks each accepted verdict and stalls at random, with long
  // stretches of steady ready mixed in.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata, m_axis_tuser);
    if (sink_hold > 0) begin
      sink_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      sink_hold     = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      sink_hold     = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
                                                    $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any transaction on either side counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    pkt_shape_t  sh;
    logic [63:0] fam_word;
    int          ph, start_bytes, pkts, r;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= stunmap_pkg::REG_FAMILY;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets under the reset settings: IPv4 and zero seeds.
    sh = base_shape();
    send_shape(sh);                        // plain MAPPED, good verdict
    sh.kind = KIND_XOR;
    send_shape(sh);                        // XOR-MAPPED, cookie-masked
    sh.fam_byte = 2;
    send_shape(sh);                        // family mismatch, nothing found
    sh = base_shape();
    sh.cut_at = 1;
    send_shape(sh);                        // one-byte packet
    sh.cut_at = 19;
    send_shape(sh);                        // one byte short of a header
    sh = base_shape();
    sh.flip_at = 0;
    send_shape(sh);                        // wrong message type
    sh.flip_at = 6;
    send_shape(sh);                        // broken cookie
    sh.flip_at = 10;
    send_shape(sh);                        // transaction id mismatch
    sh.flip_at = 19;
    send_shape(sh);                        // last id byte is not compared
    sh = base_shape();
    sh.len_field = 16'hffff;
    send_shape(sh);                        // declared length past the end
    sh.len_field = 4;
    sh.cut_at    = 28;
    send_shape(sh);                        // attribute runs past the packet end
    sh = base_shape();
    sh.n_attr = 0;
    send_shape(sh);                        // no attributes at all
    // Receive buffer truncation: the bytes past the limit are dropped.
    sh = base_shape();
    sh.kind      = KIND_XOR;
    sh.long_body = 440;
    sh.extra     = 36;
    send_shape(sh);
    drain();

    // IPv6 with random seeds.
    set_config(64'd2, {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)});
    sh = base_shape();
    sh.kind = KIND_XOR;
    send_shape(sh);
    sh.kind = KIND_MAPPED;
    send_shape(sh);
    drain();

    // Odd family values, zero and all-ones seeds.
    set_config(64'd0, 64'd0, '1);
    sh = base_shape();
    sh.kind = KIND_XOR;
    send_shape(sh);
    drain();
    set_config(64'd3, '1, '1);
    send_shape(sh);
    sh.kind = KIND_MAPPED;
    send_shape(sh);
    drain();

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 3; ph++) begin
      r = $urandom_range(0, 9);
      fam_word      = {32'($urandom), 32'($urandom)};
      fam_word[1:0] = (r < 4) ? 2'd1 : (r < 8) ? 2'd2 : (r == 8) ? 2'd0 : 2'd3;
      set_config(fam_word, seed_word(), seed_word());
      start_bytes = sent_bytes;
      pkts        = 0;
      while (sent_bytes - start_bytes < 60 || pkts < 2) begin
        send_shape(random_shape());
        pkts++;
      end
      drain();
    end

    if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
